// ===== sv/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types and constants for the door lock supervisor: phase codes,
// command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_OPEN = 2'd1,
    PH_LOCK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_REARM  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IR_THR       = 3'd0,
    CFG_PHOTO_THR    = 3'd1,
    CFG_SHOCK_THR    = 3'd2,
    CFG_QUALIFY      = 3'd3,
    CFG_FIRST_TMO    = 3'd4,
    CFG_REPEAT_TMO   = 3'd5,
    CFG_MAGNET_HOLD  = 3'd6,
    CFG_CHECK_PERIOD = 3'd7
  } cfg_idx_e;

  localparam int IR_THR_RST       = 2048;
  localparam int PHOTO_THR_RST    = 2048;
  localparam int SHOCK_THR_RST    = 4095;
  localparam int QUALIFY_RST      = 500;
  localparam int FIRST_TMO_RST    = 60000;
  localparam int REPEAT_TMO_RST   = 6000;
  localparam int MAGNET_HOLD_RST  = 1000;
  localparam int CHECK_PERIOD_RST = 2000;

endpackage

// ===== sv/door_lock_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// door_lock_supervisor_top
// Door lock supervisor: magnet countdown, debounced open/close/relock,
// repeating open timeout and periodic locked-state sensor checks.
//
//   port group   direction  handshake                 payload
//   in_*         input      in_valid_i / in_stall_o   command + samples
//   out_*        output     out_valid_o / out_stall_i phase, magnet, events
//   cfg_*        input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; each result appears in the cycle after its item is taken.
// State counters and the result register update together on acceptance.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset puts the lock in the locked phase, magnet engaged, counters cleared.
// ----------------------------------------------------------------------------
module door_lock_supervisor_top #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [SAMPLE_BITS-1:0]            infra_red_sample_i,
  input  logic [SAMPLE_BITS-1:0]            photo_sample_i,
  input  logic [SAMPLE_BITS-1:0]            shock_sample_i,
  input  logic                              switch_closed_i,
  input  logic                              address_conflict_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        lock_phase_o,
  output logic                              magnet_engaged_o,
  output logic                              opened_event_o,
  output logic                              locked_event_o,
  output logic                              open_timeout_alarm_o,
  output logic                              switch_alarm_o,
  output logic                              light_alarm_o,
  output logic                              presence_alarm_o,
  output logic                              vibration_alarm_o,
  output logic                              conflict_alarm_o,
  input  logic                              cfg_we_i,
  input  logic [dls_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [TIMER_BITS-1:0]             cfg_data_i
);
  import dls_pkg::*;

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [SAMPLE_BITS-1:0] ir_thr, photo_thr, shock_thr;
  logic [TIMER_BITS-1:0]  qualify, first_tmo, repeat_tmo, magnet_hold, check_period;

  dls_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ir_thr_o       (ir_thr),
    .photo_thr_o    (photo_thr),
    .shock_thr_o    (shock_thr),
    .qualify_o      (qualify),
    .first_tmo_o    (first_tmo),
    .repeat_tmo_o   (repeat_tmo),
    .magnet_hold_o  (magnet_hold),
    .check_period_o (check_period)
  );

  phase_e                phase_q, phase_d;
  logic                  mag_q, mag_d;
  logic [TIMER_BITS-1:0] mcnt_q, mcnt_d;
  logic [TIMER_BITS-1:0] odeb_q, odeb_d, cdeb_q, cdeb_d, rdeb_q, rdeb_d;
  logic [TIMER_BITS-1:0] otmr_q, otmr_d, chk_q, chk_d;

  logic       ev_open, ev_lock, ev_tmo;
  logic [4:0] alarms;

  logic       out_valid_q;
  logic [1:0] phase_out_q;
  logic       mag_out_q, ev_open_q, ev_lock_q, ev_tmo_q;
  logic [4:0] alarms_q;

  logic accept;
  logic ir_above, ir_below, light_low;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ir_above  = infra_red_sample_i > ir_thr;
  assign ir_below  = infra_red_sample_i < ir_thr;
  assign light_low = photo_sample_i < photo_thr;

  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    mcnt_d  = mcnt_q;
    odeb_d  = odeb_q;
    cdeb_d  = cdeb_q;
    rdeb_d  = rdeb_q;
    otmr_d  = otmr_q;
    chk_d   = chk_q;
    ev_open = 1'b0;
    ev_lock = 1'b0;
    ev_tmo  = 1'b0;
    alarms  = '0;
    case (command_i)
      CMD_UNLOCK: begin
        phase_d = PH_WAIT;
        mcnt_d  = magnet_hold;
        mag_d   = 1'b0;
      end
      CMD_REARM: begin
        if (phase_q != PH_LOCK) mcnt_d = magnet_hold;
      end
      CMD_TICK: begin
        if (chk_q != TMAX) chk_d = chk_q + 1'b1;
        if (mcnt_q != '0) begin
          mcnt_d = mcnt_q - 1'b1;
          if (mcnt_q == TIMER_BITS'(1)) mag_d = 1'b1;
        end
        case (phase_q)
          PH_WAIT: begin
            if (ir_above) begin
              if (odeb_q != '0) begin
                odeb_d = odeb_q - 1'b1;
                if (odeb_q == TIMER_BITS'(1) || !switch_closed_i || light_low) begin
                  odeb_d  = '0;
                  phase_d = PH_OPEN;
                  otmr_d  = first_tmo;
                  ev_open = 1'b1;
                end
              end else begin
                odeb_d = qualify;
              end
            end else begin
              odeb_d = '0;
            end
            if (mcnt_d == '0) begin
              if (rdeb_q != '0) begin
                rdeb_d = rdeb_q - 1'b1;
                if (rdeb_q == TIMER_BITS'(1)) begin
                  phase_d = PH_LOCK;
                  ev_lock = 1'b1;
                end
              end else begin
                rdeb_d = qualify;
              end
            end else begin
              rdeb_d = '0;
            end
          end
          PH_OPEN: begin
            if (otmr_q != '0) begin
              otmr_d = otmr_q - 1'b1;
            end else begin
              otmr_d = repeat_tmo;
              ev_tmo = 1'b1;
            end
            if (ir_below) begin
              if (cdeb_q != '0) begin
                cdeb_d = cdeb_q - 1'b1;
                if (cdeb_q == TIMER_BITS'(1) && mcnt_d == '0 &&
                    switch_closed_i && !light_low) begin
                  phase_d = PH_LOCK;
                  ev_lock = 1'b1;
                end
              end else begin
                cdeb_d = qualify;
              end
            end else begin
              cdeb_d = '0;
            end
          end
          PH_LOCK: begin
            if (chk_d > check_period) begin
              chk_d  = '0;
              alarms = {address_conflict_i, shock_sample_i > shock_thr, ir_above,
                        light_low, ~switch_closed_i};
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LOCK;
      mag_q   <= 1'b1;
      mcnt_q  <= '0;
      odeb_q  <= '0;
      cdeb_q  <= '0;
      rdeb_q  <= '0;
      otmr_q  <= '0;
      chk_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      mcnt_q  <= mcnt_d;
      odeb_q  <= odeb_d;
      cdeb_q  <= cdeb_d;
      rdeb_q  <= rdeb_d;
      otmr_q  <= otmr_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_out_q <= phase_d;
      mag_out_q   <= mag_d;
      ev_open_q   <= ev_open;
      ev_lock_q   <= ev_lock;
      ev_tmo_q    <= ev_tmo;
      alarms_q    <= alarms;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign lock_phase_o         = phase_out_q;
  assign magnet_engaged_o     = mag_out_q;
  assign opened_event_o       = ev_open_q;
  assign locked_event_o       = ev_lock_q;
  assign open_timeout_alarm_o = ev_tmo_q;
  assign switch_alarm_o       = alarms_q[0];
  assign light_alarm_o        = alarms_q[1];
  assign presence_alarm_o     = alarms_q[2];
  assign vibration_alarm_o    = alarms_q[3];
  assign conflict_alarm_o     = alarms_q[4];

  // a relock on the same tick moves an opening straight on to locked
  a_open_ev_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_open_q) |-> (phase_out_q != PH_WAIT && phase_q != PH_WAIT))
    else $error("opened event without opened phase");

  a_lock_ev_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_lock_q) |-> (phase_out_q == PH_LOCK && phase_q == PH_LOCK))
    else $error("locked event without locked phase");

  a_alarm_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && alarms_q != '0) |-> (phase_q == PH_LOCK && chk_q == '0))
    else $error("sensor alarm outside a locked-state check");

  a_tmo_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_tmo_q) |-> (otmr_q == repeat_tmo || phase_q != PH_OPEN))
    else $error("timeout alarm without timer reload");

  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no result held");

endmodule

// ===== sv/dls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dls_cfg_regs
// Configuration register file: thresholds and timer reloads, written by
// index, each keeping the low bits of the write data.
// ----------------------------------------------------------------------------
module dls_cfg_regs #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dls_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [TIMER_BITS-1:0]             cfg_data_i,
  output logic [SAMPLE_BITS-1:0]            ir_thr_o,
  output logic [SAMPLE_BITS-1:0]            photo_thr_o,
  output logic [SAMPLE_BITS-1:0]            shock_thr_o,
  output logic [TIMER_BITS-1:0]             qualify_o,
  output logic [TIMER_BITS-1:0]             first_tmo_o,
  output logic [TIMER_BITS-1:0]             repeat_tmo_o,
  output logic [TIMER_BITS-1:0]             magnet_hold_o,
  output logic [TIMER_BITS-1:0]             check_period_o
);
  import dls_pkg::*;

  logic [SAMPLE_BITS-1:0] ir_thr_q, photo_thr_q, shock_thr_q;
  logic [TIMER_BITS-1:0]  qualify_q, first_tmo_q, repeat_tmo_q;
  logic [TIMER_BITS-1:0]  magnet_hold_q, check_period_q;
  logic [SAMPLE_BITS-1:0] data_s;

  assign data_s = cfg_data_i[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_thr_q       <= SAMPLE_BITS'(IR_THR_RST);
      photo_thr_q    <= SAMPLE_BITS'(PHOTO_THR_RST);
      shock_thr_q    <= SAMPLE_BITS'(SHOCK_THR_RST);
      qualify_q      <= TIMER_BITS'(QUALIFY_RST);
      first_tmo_q    <= TIMER_BITS'(FIRST_TMO_RST);
      repeat_tmo_q   <= TIMER_BITS'(REPEAT_TMO_RST);
      magnet_hold_q  <= TIMER_BITS'(MAGNET_HOLD_RST);
      check_period_q <= TIMER_BITS'(CHECK_PERIOD_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IR_THR:       ir_thr_q       <= data_s;
        CFG_PHOTO_THR:    photo_thr_q    <= data_s;
        CFG_SHOCK_THR:    shock_thr_q    <= data_s;
        CFG_QUALIFY:      qualify_q      <= cfg_data_i;
        CFG_FIRST_TMO:    first_tmo_q    <= cfg_data_i;
        CFG_REPEAT_TMO:   repeat_tmo_q   <= cfg_data_i;
        CFG_MAGNET_HOLD:  magnet_hold_q  <= cfg_data_i;
        CFG_CHECK_PERIOD: check_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ir_thr_o       = ir_thr_q;
  assign photo_thr_o    = photo_thr_q;
  assign shock_thr_o    = shock_thr_q;
  assign qualify_o      = qualify_q;
  assign first_tmo_o    = first_tmo_q;
  assign repeat_tmo_o   = repeat_tmo_q;
  assign magnet_hold_o  = magnet_hold_q;
  assign check_period_o = check_period_q;

endmodule
